[sv/sres_pkg.sv]
// Shared constants and types for the systematic resampler.
// No dependencies; imported by systematic_resampler_unit.
`default_nettype none

package sres_pkg;

   localparam int TABLE_DEPTH   = 2048;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = IDX_W + 1;
   localparam int WEIGHT_W      = 32;
   localparam int OFFSET_W      = 16;
   localparam int TOTAL_W       = WEIGHT_W + IDX_W;
   localparam int TARGET_W      = OFFSET_W + CNT_W;
   localparam int LHS_W         = TARGET_W + TOTAL_W;
   localparam int RHS_W         = TOTAL_W + CNT_W;
   localparam int PROD_W        = WEIGHT_W + CNT_W;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REFUSE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_ACC,
      ST_CHECK,
      ST_EMIT
   } st_type;

endpackage

`default_nettype wire

[sv/systematic_resampler_unit.sv]
// Systematic resampler: weight table in one synchronous RAM, walk sequencer.
// Depends on sres_pkg.
//
// Usage: req_ items with kind load store one weight each while the table has
// room (restart empties the table first); a load completes in the cycle it
// is accepted and gives no rsp_ item. Each draw item gives exactly one rsp_
// item: the next index of the systematic resampling walk, last on draw N, or
// status refuse when nothing is loaded or all N draws are done. Any load
// cancels the round. After a draw is accepted, each step of the walk index
// takes a RAM read, a weight * N multiply and an accumulate, and the first
// draw of a round first fetches weight 0 the same way. The walk moves at most
// N-1 steps per round.
// req_stall is high while a draw is in progress. A finished item waits in
// the rsp_ output register; the next req_ item is taken meanwhile, and its
// result is held until rsp_stall drops. Reset empties the table and round.
// The comparison (offset + m*2^16) * total > cumulative * N * 2^16 is done
// on exact products kept incrementally, so no weight is normalized.
`default_nettype none

module systematic_resampler_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_kind,
   input  wire logic [sres_pkg::WEIGHT_W-1:0] req_weight,
   input  wire logic                          req_restart,
   input  wire logic [sres_pkg::OFFSET_W-1:0] req_offset,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [sres_pkg::IDX_W-1:0]    rsp_particle_index,
   output      logic                          rsp_last,
   output      logic                          rsp_status
);
   import sres_pkg::*;

   logic [WEIGHT_W-1:0] mem [TABLE_DEPTH];
   logic [WEIGHT_W-1:0] rd_data_ff;

   st_type              state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [CNT_W-1:0]    draw_ff;
   logic [IDX_W-1:0]    walk_ff;
   logic [OFFSET_W-1:0] start_ff;
   logic [LHS_W-1:0]    lhs_ff;
   logic [RHS_W-1:0]    rhs_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                first_ff;
   logic                err_ff;
   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    rsp_index_ff;
   logic                rsp_last_ff;
   logic                rsp_status_ff;

   logic                accept, do_load, do_draw;
   logic [CNT_W-1:0]    base_cnt;
   logic                load_room;
   logic                draw_bad, draw_first;
   logic                can_step, target_pos, beyond, advance;
   logic                rsp_free;
   logic                mem_rd_en;
   logic [IDX_W-1:0]    mem_rd_addr;

   // control decode
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      accept      = req_valid && !req_stall;
      do_load     = accept && (req_kind == KIND_LOAD);
      do_draw     = accept && (req_kind == KIND_DRAW);
      base_cnt    = req_restart ? '0 : cnt_ff;
      load_room   = (base_cnt < CNT_W'(TABLE_DEPTH));
      draw_bad    = (cnt_ff == '0) || (draw_ff >= cnt_ff);
      draw_first  = (draw_ff == '0);
      can_step    = (({1'b0, walk_ff} + CNT_W'(1)) < cnt_ff);
      target_pos  = (start_ff != '0) || (draw_ff != '0);
      // with a zero total the target is beyond as soon as it is positive
      beyond      = (total_ff == '0) ? target_pos
                                     : (lhs_ff > {rhs_ff, {OFFSET_W{1'b0}}});
      advance     = can_step && beyond;
      rsp_free    = !rsp_valid_ff || !rsp_stall;
      mem_rd_en   = (do_draw && !draw_bad && draw_first) ||
                    ((state_ff == ST_CHECK) && advance);
      mem_rd_addr = (state_ff == ST_CHECK) ? (walk_ff + IDX_W'(1)) : '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (do_draw) begin
               if (draw_bad)        state_in = ST_EMIT;
               else if (draw_first) state_in = ST_RD;
               else                 state_in = ST_CHECK;
            end
         end
         ST_RD:    state_in = ST_ACC;
         ST_ACC:   state_in = ST_CHECK;
         ST_CHECK: state_in = advance ? ST_RD : ST_EMIT;
         ST_EMIT:  state_in = rsp_free ? ST_IDLE : ST_EMIT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // weight RAM
   always_ff @(posedge clock) begin
      if (do_load && load_room) begin
         mem[base_cnt[IDX_W-1:0]] <= req_weight;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         total_ff     <= '0;
         draw_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_load) begin
            draw_ff <= '0;
            if (load_room) begin
               cnt_ff   <= base_cnt + CNT_W'(1);
               total_ff <= (req_restart ? '0 : total_ff) + TOTAL_W'(req_weight);
            end
         end
         if (do_draw) begin
            err_ff   <= draw_bad;
            first_ff <= !draw_bad && draw_first;
         end
         if (state_ff == ST_ACC) begin
            first_ff <= 1'b0;
         end
         if ((state_ff == ST_EMIT) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            if (!err_ff) begin
               draw_ff <= draw_ff + CNT_W'(1);
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // walk datapath
   always_ff @(posedge clock) begin
      if (do_draw && !draw_bad && draw_first) begin
         start_ff <= req_offset;
         lhs_ff   <= LHS_W'(req_offset * total_ff);
      end
      if (state_ff == ST_RD) begin
         walk_ff  <= first_ff ? '0 : (walk_ff + IDX_W'(1));
         prod_ff  <= PROD_W'(rd_data_ff * cnt_ff);
      end
      if (state_ff == ST_ACC) begin
         rhs_ff <= (first_ff ? '0 : rhs_ff) + RHS_W'(prod_ff);
      end
      if ((state_ff == ST_EMIT) && rsp_free) begin
         if (err_ff) begin
            rsp_index_ff  <= '0;
            rsp_last_ff   <= 1'b0;
            rsp_status_ff <= STATUS_REFUSE;
         end else begin
            rsp_index_ff  <= walk_ff;
            rsp_last_ff   <= ((draw_ff + CNT_W'(1)) == cnt_ff);
            rsp_status_ff <= STATUS_OK;
            // move the target one step on for the next draw
            lhs_ff        <= lhs_ff + {total_ff, {OFFSET_W{1'b0}}};
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_particle_index = rsp_index_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

`default_nettype wire
